@@ design/page_table_first_fit_pager_defines.svh @@
// Assertion macros used by the page table pager top level.
`ifndef PAGE_TABLE_FIRST_FIT_PAGER_DEFINES_SVH
`define PAGE_TABLE_FIRST_FIT_PAGER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PTFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptff assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PTFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptff assertion failed");
`else
`define PTFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/ptff_pkg.sv @@
// Shared constants for the page table pager.
package ptff_pkg;
	localparam int unsigned MEM_BYTES_DEF         = 65536;
	localparam int unsigned PAGE_BYTES_DEF        = 1024;
	localparam int unsigned PAGES_PER_SEGMENT_DEF = 256;

	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned PAGE_W  = 8;
	localparam int unsigned ENTRY_W = 32;

	localparam logic [ENTRY_W-1:0] PRESENT_MARK = 32'h0000_0200;
	localparam int unsigned        PRESENT_BIT  = 9;

	localparam logic FUNC_TRANSLATE = 1'b0;
	localparam logic FUNC_RESERVE   = 1'b1;
endpackage

@@ design/ptff_intf.sv @@
// Request and response channel interfaces of the page table pager.
interface ptff_req_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [ptff_pkg::ADDR_W-1:0] seg_base;
	logic [ptff_pkg::PAGE_W-1:0] vpn;
	logic [ptff_pkg::ADDR_W-1:0] range_start;
	logic [ptff_pkg::ADDR_W-1:0] range_end;

	modport source (output valid, func, seg_base, vpn, range_start, range_end,
		input ready);
	modport sink (input valid, func, seg_base, vpn, range_start, range_end,
		output ready);
endinterface

interface ptff_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ptff_pkg::ADDR_W-1:0] phys_addr;
	logic                        page_fault;
	logic                        memory_full;

	modport source (output valid, phys_addr, page_fault, memory_full, input ready);
	modport sink (input valid, phys_addr, page_fault, memory_full, output ready);
endinterface

@@ design/ptff_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
module ptff_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ design/page_table_first_fit_pager.sv @@
// Top level of the page table pager: control sequencer and both stores.
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------------
//   req     | in  | func, seg_base, vpn, range_start, range_end
//   rsp     | out | phys_addr, page_fault, memory_full
//
// After reset a clearing pass writes zero to every entry word and every
// occupancy row; no request is taken until it ends. A fault scans the
// occupancy map one row of 32 bytes (16 when a page is smaller) per cycle,
// then marks each row of the page it takes. A reserve reads and rewrites
// each occupancy row it touches. A finished result sits in the output
// register, so the next request is accepted while the consumer stalls.
`include "page_table_first_fit_pager_defines.svh"

module page_table_first_fit_pager #(
	parameter int unsigned MEM_BYTES         = ptff_pkg::MEM_BYTES_DEF,
	parameter int unsigned PAGE_BYTES        = ptff_pkg::PAGE_BYTES_DEF,
	parameter int unsigned PAGES_PER_SEGMENT = ptff_pkg::PAGES_PER_SEGMENT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ptff_req_if.sink  req,
	ptff_rsp_if.source rsp
);
	// Occupancy rows never exceed a page of 16 bytes or more, so a run that
	// completes in a row always touches the row's low end.
	localparam int unsigned MAP_W       = (PAGE_BYTES >= 32) ? 32 : 16;
	localparam int unsigned LOGW        = $clog2(MAP_W);
	localparam int unsigned MAP_ROWS    = MEM_BYTES / MAP_W;
	localparam int unsigned MR_W        = $clog2(MAP_ROWS);
	localparam int unsigned MA_W        = $clog2(MEM_BYTES);
	localparam int unsigned ENTRY_WORDS = MEM_BYTES / 4;
	localparam int unsigned EW_W        = $clog2(ENTRY_WORDS);
	localparam int unsigned RUN_W       = $clog2(PAGE_BYTES + 1);
	localparam int unsigned TZ_W        = $clog2(MAP_W + 1);
	localparam int unsigned RECIP       = (65536 + PAGES_PER_SEGMENT - 1) / PAGES_PER_SEGMENT;
	localparam int unsigned AW          = ptff_pkg::ADDR_W;
	localparam int unsigned PW          = ptff_pkg::PAGE_W;
	localparam int unsigned EW          = ptff_pkg::ENTRY_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV, S_WORD, S_LOOK, S_CHECK, S_SCAN, S_MARK, S_DONE
	} state_t;

	state_t             state_q;
	logic [EW_W-1:0]    clr_q;
	logic               func_q;
	logic [AW-1:0]      seg_q;
	logic [PW-1:0]      page_q;
	logic [AW-1:0]      rs_q;
	logic [AW-1:0]      re_q;
	logic [PW-1:0]      quot_q;
	logic [EW_W-1:0]    word_q;
	logic [RUN_W-1:0]   run_q;
	logic [MR_W:0]      iss_row_q;
	logic               pend_s1;
	logic [MR_W-1:0]    row_s1;
	logic [MA_W-1:0]    lo_q;
	logic [MA_W-1:0]    hi_q;
	logic [AW-1:0]      res_addr_q;
	logic               res_fault_q;
	logic               res_full_q;
	logic               out_valid_q;
	logic [AW-1:0]      out_addr_q;
	logic               out_fault_q;
	logic               out_full_q;

	// Memory ports.
	logic               ent_we, ent_re;
	logic [EW_W-1:0]    ent_waddr;
	logic [EW-1:0]      ent_wdata, ent_rdata;
	logic               map_we, map_re;
	logic [MR_W-1:0]    map_waddr, map_raddr;
	logic [MAP_W-1:0]   map_wdata, map_rdata;

	// Row analysis and address arithmetic.
	logic [TZ_W-1:0]    tz, lz;
	logic               row_zero;
	logic               fit;
	logic               sc_found;
	logic [MA_W-1:0]    start;
	logic [RUN_W-1:0]   run_next;
	logic [MAP_W-1:0]   mark_mask;
	logic [MR_W-1:0]    lo_row, hi_row;
	logic [LOGW-1:0]    lo_bit, hi_bit;
	logic [31:0]        rem32, sum32, rs32, re32;
	logic               scan_done, mark_done;

	ptff_ram #(.WIDTH(EW), .DEPTH(ENTRY_WORDS)) u_entry (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(word_q), .rdata(ent_rdata)
	);

	ptff_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ROWS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(map_re), .raddr(map_raddr), .rdata(map_rdata)
	);

	// Trailing free bytes (low end) and leading free bytes (high end) of a row.
	always_comb begin
		tz = TZ_W'(MAP_W);
		lz = TZ_W'(MAP_W);
		for (int i = MAP_W - 1; i >= 0; i--) begin
			if (map_rdata[i]) begin
				tz = TZ_W'(i);
			end
		end
		for (int i = 0; i < MAP_W; i++) begin
			if (map_rdata[i]) begin
				lz = TZ_W'(MAP_W - 1 - i);
			end
		end
	end

	assign row_zero  = (map_rdata == '0);
	assign fit       = (32'(run_q) + 32'(tz)) >= PAGE_BYTES;
	assign sc_found  = (state_q == S_SCAN) && pend_s1 && fit;
	assign start     = MA_W'((32'(row_s1) << LOGW) - 32'(run_q));
	assign run_next  = row_zero ? RUN_W'(32'(run_q) + MAP_W) : RUN_W'(lz);
	assign scan_done = iss_row_q[MR_W:0] == (MR_W + 1)'(MAP_ROWS);
	assign mark_done = iss_row_q > {1'b0, hi_row};

	assign lo_row = lo_q[MA_W-1:LOGW];
	assign hi_row = hi_q[MA_W-1:LOGW];
	assign lo_bit = lo_q[LOGW-1:0];
	assign hi_bit = hi_q[LOGW-1:0];

	// Bytes of the current row that fall inside the inclusive range lo..hi.
	always_comb begin
		mark_mask = '1;
		if (row_s1 == lo_row) begin
			mark_mask = mark_mask & ({MAP_W{1'b1}} << lo_bit);
		end
		if (row_s1 == hi_row) begin
			mark_mask = mark_mask & ({MAP_W{1'b1}} >> (LOGW'(MAP_W - 1) - hi_bit));
		end
	end

	// Page number modulo the segment size, then the entry word with wrap.
	assign rem32 = 32'(page_q) - 32'(quot_q) * PAGES_PER_SEGMENT;
	always_comb begin
		sum32 = 32'(seg_q >> 2) + rem32;
		if (sum32 >= ENTRY_WORDS) begin
			sum32 = sum32 - ENTRY_WORDS;
		end
	end

	assign rs32 = 32'(rs_q);
	assign re32 = 32'(re_q);

	// Memory port steering.
	always_comb begin
		ent_we    = 1'b0;
		ent_re    = 1'b0;
		ent_waddr = word_q;
		ent_wdata = EW'(32'(start)) + ptff_pkg::PRESENT_MARK;
		map_we    = 1'b0;
		map_re    = 1'b0;
		map_waddr = row_s1;
		map_raddr = iss_row_q[MR_W-1:0];
		map_wdata = map_rdata | mark_mask;
		unique case (state_q)
			S_CLEAR: begin
				ent_we    = 1'b1;
				ent_waddr = clr_q;
				ent_wdata = '0;
				map_we    = 32'(clr_q) < MAP_ROWS;
				map_waddr = clr_q[MR_W-1:0];
				map_wdata = '0;
			end
			S_LOOK: begin
				ent_re = 1'b1;
			end
			S_SCAN: begin
				map_re = !scan_done && !sc_found;
				ent_we = sc_found;
			end
			S_MARK: begin
				map_re = !mark_done;
				map_we = pend_s1;
			end
			default: begin
			end
		endcase
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.phys_addr   = out_addr_q;
	assign rsp.page_fault  = out_fault_q;
	assign rsp.memory_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In S_DONE the output register is refilled below instead.
			if (rsp.ready && out_valid_q && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == ENTRY_WORDS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						func_q  <= req.func;
						seg_q   <= req.seg_base;
						page_q  <= req.vpn;
						rs_q    <= req.range_start;
						re_q    <= req.range_end;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quot_q <= PW'((32'(page_q) * RECIP) >> 16);
					res_addr_q  <= '0;
					res_fault_q <= 1'b0;
					res_full_q  <= 1'b0;
					if (func_q == ptff_pkg::FUNC_RESERVE) begin
						if (rs32 <= re32 && rs32 < MEM_BYTES) begin
							lo_q      <= MA_W'(rs32);
							hi_q      <= (re32 >= MEM_BYTES) ? MA_W'(MEM_BYTES - 1) : MA_W'(re32);
							iss_row_q <= (MR_W + 1)'(rs32 >> LOGW);
							pend_s1   <= 1'b0;
							state_q   <= S_MARK;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_WORD;
					end
				end
				S_WORD: begin
					word_q  <= EW_W'(sum32);
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (ent_rdata[ptff_pkg::PRESENT_BIT]) begin
						res_addr_q <= AW'(ent_rdata - ptff_pkg::PRESENT_MARK);
						state_q    <= S_DONE;
					end else begin
						run_q     <= '0;
						iss_row_q <= '0;
						pend_s1   <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					// No read is issued in the cycle that finds a run, so
					// the pipeline empties by itself here.
					pend_s1 <= map_re;
					if (map_re) begin
						iss_row_q <= iss_row_q + 1'b1;
						row_s1    <= iss_row_q[MR_W-1:0];
					end
					if (pend_s1) begin
						if (fit) begin
							lo_q        <= start;
							hi_q        <= MA_W'(32'(start) + PAGE_BYTES - 1);
							iss_row_q   <= {1'b0, start[MA_W-1:LOGW]};
							res_addr_q  <= AW'(start);
							res_fault_q <= 1'b1;
							state_q     <= S_MARK;
						end else begin
							run_q <= run_next;
							if (32'(row_s1) == MAP_ROWS - 1) begin
								res_full_q <= 1'b1;
								state_q    <= S_DONE;
							end
						end
					end
				end
				S_MARK: begin
					pend_s1 <= map_re;
					if (map_re) begin
						iss_row_q <= iss_row_q + 1'b1;
						row_s1    <= iss_row_q[MR_W-1:0];
					end
					if (!map_re && !pend_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= res_addr_q;
						out_fault_q <= res_fault_q;
						out_full_q  <= res_full_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PTFF_ASSERT_IMP(a_flags_exclusive, clk, arst_n, rsp.valid, !(rsp.page_fault && rsp.memory_full))
	`PTFF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready)
	`PTFF_ASSERT_IMP(a_closed_in_clear, clk, arst_n, state_q == S_CLEAR, !req.ready)
	`PTFF_ASSERT_IMP(a_full_zero_addr, clk, arst_n, rsp.valid && rsp.memory_full, rsp.phys_addr == '0)
	`PTFF_ASSERT_IMP(a_entry_write_on_fault, clk, arst_n, ent_we && state_q != S_CLEAR, sc_found)
endmodule

@@ tb/page_table_first_fit_pager_checker.sv @@
// Checker for the page table pager: predicts every response and compares it.
`timescale 1ns / 100ps

module page_table_first_fit_pager_checker (
	input  logic clk,
	input  logic arst_n,
	ptff_req_if  req,
	ptff_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);
	localparam int unsigned MEM   = ptff_pkg::MEM_BYTES_DEF;
	localparam int unsigned PAGE  = ptff_pkg::PAGE_BYTES_DEF;
	localparam int unsigned WORDS = ptff_pkg::MEM_BYTES_DEF / 4;
	localparam int unsigned AW    = ptff_pkg::ADDR_W;
	localparam int unsigned PW    = ptff_pkg::PAGE_W;
	localparam int unsigned EW    = ptff_pkg::ENTRY_W;

	typedef struct packed {
		logic [AW-1:0] phys_addr;
		logic          page_fault;
		logic          memory_full;
	} pager_result_t;

	bit            byte_used [MEM];
	logic [EW-1:0] pte_words [WORDS];
	pager_result_t expected_responses [$];

	function automatic void mark_bytes(input int unsigned first, input int unsigned last);
		int unsigned top;
		if (first > last || first >= MEM)
			return;
		top = (last >= MEM) ? MEM - 1 : last;
		for (int unsigned a = first; a <= top; a++)
			byte_used[a] = 1'b1;
	endfunction

	// First free run of a page's length, searched upward from byte zero.
	function automatic bit find_free_run(output int unsigned start);
		int unsigned run;
		run = 0;
		start = 0;
		for (int unsigned a = 0; a < MEM; a++) begin
			if (!byte_used[a]) begin
				run++;
				if (run == PAGE) begin
					start = a + 1 - PAGE;
					return 1'b1;
				end
			end else begin
				run = 0;
			end
		end
		return 1'b0;
	endfunction

	function automatic pager_result_t walk_and_allocate(input logic f,
		input logic [AW-1:0] seg, input logic [PW-1:0] pg,
		input logic [AW-1:0] rs, input logic [AW-1:0] re);
		pager_result_t r;
		int unsigned   word, start;
		logic [EW-1:0] pte, diff;
		r = '0;
		if (f == ptff_pkg::FUNC_RESERVE) begin
			mark_bytes(rs, re);
		end else begin
			word = ((32'(seg) >> 2) + (32'(pg) % ptff_pkg::PAGES_PER_SEGMENT_DEF)) % WORDS;
			pte = pte_words[word];
			if (pte[ptff_pkg::PRESENT_BIT]) begin
				diff = pte - ptff_pkg::PRESENT_MARK;
				r.phys_addr = diff[AW-1:0];
			end else if (find_free_run(start)) begin
				mark_bytes(start, start + PAGE - 1);
				pte_words[word] = start + ptff_pkg::PRESENT_MARK;
				r.phys_addr = start[AW-1:0];
				r.page_fault = 1'b1;
			end else begin
				r.memory_full = 1'b1;
			end
		end
		return r;
	endfunction

	assign pending = expected_responses.size();

	initial begin
		fail_count = 0;
		foreach (pte_words[i])
			pte_words[i] = '0;
	end

	// Responses are handled before requests, since a response never
	// belongs to the request taken at the same edge.
	always @(posedge clk) begin
		pager_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_responses.size() == 0) begin
				$error("response beat with nothing expected");
				fail_count++;
			end else begin
				want = expected_responses.pop_front();
				if (rsp.phys_addr !== want.phys_addr) begin
					$error("phys_addr expected %h actual %h", want.phys_addr,
						rsp.phys_addr);
					fail_count++;
				end
				if (rsp.page_fault !== want.page_fault) begin
					$error("page_fault expected %b actual %b", want.page_fault,
						rsp.page_fault);
					fail_count++;
				end
				if (rsp.memory_full !== want.memory_full) begin
					$error("memory_full expected %b actual %b", want.memory_full,
						rsp.memory_full);
					fail_count++;
				end
			end
		end
		if (arst_n && req.valid && req.ready)
			expected_responses.push_back(walk_and_allocate(req.func, req.seg_base,
				req.vpn, req.range_start, req.range_end));
	end
endmodule

@@ tb/page_table_first_fit_pager_tb.sv @@
// Top of the page table pager testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module page_table_first_fit_pager_tb;
	localparam int unsigned AW = ptff_pkg::ADDR_W;
	localparam int unsigned PW = ptff_pkg::PAGE_W;

	logic clk;
	logic arst_n;
	int   fail_count, pending;

	// Idle and stall odds, in percent, changed per phase by the stimulus.
	int send_idle_pct, stall_pct;

	// The long receiver hold is requested here and counted down in the
	// receiver process itself.
	int hold_req, hold_done, hold_left;

	// Translate targets already sent, so that most later lookups can hit.
	logic [AW-1:0] used_seg [$];
	logic [PW-1:0] used_page [$];

	ptff_req_if req ();
	ptff_rsp_if rsp ();

	page_table_first_fit_pager DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	page_table_first_fit_pager_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: random stalls, or a long hold that lets the block back up
	// into its request channel while the sender keeps offering beats.
	always @(posedge clk) begin
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offers one request beat and returns at the edge that accepts it,
	// then maybe leaves the channel idle for a while.
	task automatic send_beat(input logic f, input logic [AW-1:0] seg,
		input logic [PW-1:0] pg, input logic [AW-1:0] rs,
		input logic [AW-1:0] re);
		req.valid       <= 1'b1;
		req.func        <= f;
		req.seg_base    <= seg;
		req.vpn         <= pg;
		req.range_start <= rs;
		req.range_end   <= re;
		do
			@(posedge clk);
		while (!req.ready);
		if (f == ptff_pkg::FUNC_TRANSLATE) begin
			used_seg.push_back(seg);
			used_page.push_back(pg);
		end
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic translate(input logic [AW-1:0] seg, input logic [PW-1:0] pg);
		send_beat(ptff_pkg::FUNC_TRANSLATE, seg, pg, AW'($urandom), AW'($urandom));
	endtask

	task automatic reserve(input logic [AW-1:0] rs, input logic [AW-1:0] re);
		send_beat(ptff_pkg::FUNC_RESERVE, AW'($urandom), PW'($urandom), rs, re);
	endtask

	// The channel goes idle first so the last beat is not offered again.
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int fresh, pick, roll, len;
		logic [AW-1:0] rs, re;
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.func        <= ptff_pkg::FUNC_TRANSLATE;
		req.seg_base    <= '0;
		req.vpn         <= '0;
		req.range_start <= '0;
		req.range_end   <= '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 0;
		hold_done     = 0;
		hold_left     = 0;
		fresh         = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A miss then a hit on the same page, and a segment
		// base with its low bits set that wraps past the end of the table
		// and lands on the same word as its aligned twin.
		translate(16'h0000, 8'h00);
		translate(16'h0000, 8'h00);
		translate(16'hFFFF, 8'hFF);
		translate(16'hFFFC, 8'hFF);
		// Leaves the first free byte at an address with the present bit
		// set, so the stored entry carries and reads back as absent.
		reserve(16'h0800, 16'h0AFF);
		translate(16'h0004, 8'h00);
		translate(16'h0004, 8'h00);
		// Reversed ranges mark nothing; a single byte marks one.
		reserve(16'h2000, 16'h1000);
		reserve(16'h1300, 16'h12FF);
		reserve(16'h0000, 16'h0000);
		reserve(16'h1800, 16'h1800);
		translate(16'h1230, 8'h80);
		translate(16'h0000, 8'hFF);
		translate(16'h1230, 8'h80);
		translate(16'h5555, 8'hAA);
		translate(16'hAAA8, 8'h55);
		fresh = 8;

		// Random part in four idling phases. Fresh pages are capped so the
		// top page of memory is still free for the end-of-memory case.
		for (int i = 0; i < 560; i++) begin
			case (i * 4 / 560)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 61; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 61; end
				default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase
			if (i == 60)
				hold_req++;
			if (i == 300)
				wait_drained();
			roll = int'($urandom_range(99));
			if (roll < 15 && fresh < 35) begin
				fresh++;
				translate(AW'($urandom), PW'($urandom));
			end else if (roll < 72 && used_seg.size() > 0) begin
				pick = int'($urandom_range(used_seg.size() - 1));
				translate(used_seg[pick], used_page[pick]);
			end else begin
				// Mostly short ranges below the top page; some reversed,
				// a few long.
				rs = AW'($urandom_range(16'hFBFF));
				len = ($urandom_range(15) == 0) ? int'($urandom_range(8191))
					: int'($urandom_range(40));
				re = (32'(rs) + 32'(len) > 32'hFBFF) ? 16'hFBFF : AW'(32'(rs) + 32'(len));
				if ($urandom_range(7) == 0)
					re = AW'($urandom_range(32'(rs)));
				reserve(rs, re);
			end
		end

		// Tail: fill all but the last page, allocate the run that ends on
		// the last byte, then run out of memory.
		send_idle_pct = 0;
		stall_pct     = 0;
		reserve(16'h0000, 16'hFBFF);
		translate(16'h8000, 8'h01);
		translate(16'h8000, 8'h01);
		reserve(16'hFFFF, 16'hFFFF);
		translate(16'h9000, 8'h02);
		translate(16'h9000, 8'h02);
		reserve(16'h0000, 16'hFFFF);
		req.valid <= 1'b0;

		wait_drained();
		repeat (2200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("page_table_first_fit_pager_tb passed");
		end else begin
			$display("page_table_first_fit_pager_tb failed");
		end
		$finish;
	end

	// Generous bound: clearing pass plus every beat at its worst scan.
	initial begin
		#200ms;
		$display("page_table_first_fit_pager_tb failed");
		$finish;
	end
endmodule

@@ page_table_first_fit_pager.f @@
+incdir+design
design/ptff_pkg.sv
design/ptff_intf.sv
design/ptff_ram.sv
design/page_table_first_fit_pager.sv
tb/page_table_first_fit_pager_checker.sv
tb/page_table_first_fit_pager_tb.sv
